>>> hw/rtl/ffha_pkg.sv
// Package: constants, status codes and sizes for the first-fit heap allocator.
package ffha_pkg;
    localparam int unsigned HEAP_BYTES_DEF   = 8388608;
    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned HEADER_BYTES_DEF = 32;
    localparam int unsigned ALIGN_BYTES_DEF  = 16;
    localparam logic [23:0] BASE_RESET       = 24'h200000;

    localparam int unsigned FW = 24;
    localparam int unsigned OW = 23;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_BASE   = 1'b1;
endpackage

>>> hw/rtl/ffha_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ffha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/first_fit_heap_allocator_core.sv
// Top level: first-fit heap allocator with block splitting and coalescing.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: request_bytes, block_address; tuser: operation
//  m_axis    | out       | tdata: result_address, status, used, free, total bytes
//  cfg       | in        | index 0 heap_enabled, index 1 heap_base
//
// A transaction walks the table entries in order; an insert or remove moves
// the entries behind the block one at a time, each read and then written back.
// Reset clears the table to one free block; no clearing pass is needed.
// The input is held off while a transaction runs; a finished result waits in
// the output register and the next input is taken meanwhile.
module first_fit_heap_allocator_core #(
    parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // [23:0] request_bytes, [47:24] block_address
    input  logic         s_axis_tuser,   // [0] operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [23:0] result_address, [25:24] status,
                                         // [49:26] used, [73:50] free, [97:74] total
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [23:0]  i_cfg_wdata
);
    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned EW = ffha_pkg::OW + ffha_pkg::FW + 1;
    localparam int unsigned LA = $clog2(ALIGN_BYTES);
    localparam logic [24:0] HDR   = 25'(HEADER_BYTES);
    localparam logic [24:0] ALN   = 25'(ALIGN_BYTES);
    localparam logic [23:0] INIT_SZ = 24'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [23:0] TOTAL   = 24'(HEAP_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_SPLIT, S_SHR_RD, S_SHR_WR, S_INS,
        S_MRG_RD, S_MRG_CHK, S_PRV_RD, S_PRV_CHK, S_INS_WR, S_SHL_RD, S_SHL_WR,
        S_SHL_END, S_DONE
    } t_state;

    t_state r_state;
    logic         r_en;
    logic [23:0]  r_base;
    logic         r_op;
    logic [24:0]  r_size;
    logic [23:0]  r_addr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_tgt;
    logic [CW-1:0] r_stop;
    logic [EW-1:0] r_cur;
    logic [EW-1:0] r_hold;
    logic [23:0]  r_used;
    logic [23:0]  r_free;
    logic [23:0]  r_res;
    logic [1:0]   r_st;
    logic         r_ovalid;
    logic [103:0] r_odata;
    logic         r_hit;

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [EW-1:0] w_wd;
    logic [AW-1:0] w_ra;
    logic [EW-1:0] w_rd;

    ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_wa),
        .i_wdata(w_wd),
        .i_raddr(w_ra),
        .o_rdata(w_rd)
    );

    // entry 0 is served from reset values until first written
    logic          r_e0w;
    logic [AW-1:0] r_ra;
    logic [EW-1:0] rd;
    assign rd = (r_ra == '0 && !r_e0w) ? {23'd0, INIT_SZ, 1'b1} : w_rd;

    logic [22:0] rd_off;
    logic [23:0] rd_sz;
    logic        rd_fr;
    assign rd_off = rd[EW-1 -: 23];
    assign rd_sz  = rd[24:1];
    assign rd_fr  = rd[0];

    logic [23:0] rd_pa;
    assign rd_pa = r_base + 24'(rd_off) + 24'(HEADER_BYTES);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_k[AW-1:0];
        w_wd = r_hold;
        w_ra = r_i[AW-1:0];
        case (r_state)
            S_SHR_RD: w_ra = r_k[AW-1:0] - AW'(1);
            S_SHR_WR: begin w_we = 1'b1; w_wd = rd; end
            S_INS, S_SPLIT, S_INS_WR: begin w_we = 1'b1; w_wa = r_tgt[AW-1:0]; end
            S_MRG_RD: w_ra = r_i[AW-1:0] + AW'(1);
            S_PRV_RD: w_ra = r_i[AW-1:0] - AW'(1);
            S_SHL_RD: w_ra = r_k[AW-1:0] + AW'(1);
            S_SHL_WR: begin w_we = 1'b1; w_wd = rd; end
            S_SHL_END: w_ra = r_i[AW-1:0] - AW'(1);
            S_MRG_CHK, S_PRV_CHK: begin w_we = 1'b1; w_wa = r_tgt[AW-1:0]; end
            default: ;
        endcase
    end

    logic [24:0] w_big;
    assign w_big = r_size + HDR + ALN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b0;
            r_base   <= ffha_pkg::BASE_RESET;
            r_cnt    <= CW'(1);
            r_used   <= '0;
            r_free   <= INIT_SZ;
            r_ovalid <= 1'b0;
            r_odata  <= '0;
            r_e0w    <= 1'b0;
            r_ra     <= '0;
        end else begin
            r_ra <= w_ra;
            if (w_we && w_wa == '0) begin
                r_e0w <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == ffha_pkg::REG_ENABLE) begin
                    r_en <= i_cfg_wdata[0];
                end else begin
                    r_base <= i_cfg_wdata;
                end
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op   <= s_axis_tuser;
                        r_addr <= s_axis_tdata[47:24];
                        r_size <= ((25'(s_axis_tdata[23:0]) + ALN - 25'd1) >> LA) << LA;
                        r_i    <= '0;
                        r_res  <= '0;
                        if (!r_en || (s_axis_tuser == ffha_pkg::OP_ALLOC
                                ? s_axis_tdata[23:0] == '0 : s_axis_tdata[47:24] == '0)) begin
                            r_st  <= ffha_pkg::ST_INVALID;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_i >= r_cnt) begin
                        r_st <= (r_op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_OOM
                                                             : ffha_pkg::ST_UNKNOWN;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cur <= rd;
                    r_tgt <= r_i;
                    if (r_op == ffha_pkg::OP_ALLOC) begin
                        if (rd_fr && 25'(rd_sz) >= r_size) begin
                            r_res <= rd_pa;
                            r_st  <= ffha_pkg::ST_OK;
                            if (25'(rd_sz) > w_big && r_cnt < CW'(MAX_BLOCKS)) begin
                                r_hold <= {rd_off, r_size[23:0], 1'b0};
                                r_used <= r_used + r_size[23:0];
                                r_free <= r_free - r_size[23:0] - 24'(HEADER_BYTES);
                                r_state <= S_SPLIT;
                            end else begin
                                r_hold <= {rd_off, rd_sz, 1'b0};
                                r_used <= r_used + rd_sz;
                                r_free <= r_free - rd_sz;
                                r_state <= S_INS;
                                r_stop  <= '0;
                            end
                        end else begin
                            r_i <= r_i + CW'(1);
                            r_state <= S_RD;
                        end
                    end else if (rd_pa == r_addr) begin
                        if (rd_fr) begin
                            r_st <= ffha_pkg::ST_UNKNOWN;
                            r_state <= S_DONE;
                        end else begin
                            r_st   <= ffha_pkg::ST_OK;
                            r_hold <= {rd_off, rd_sz, 1'b1};
                            r_used <= r_used - rd_sz;
                            r_free <= r_free + rd_sz;
                            r_state <= S_INS;
                            r_stop  <= CW'(1);
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_SPLIT: begin
                    // write shrunk block, then open a slot after it
                    r_hold <= {rd_off + 23'(HEADER_BYTES) + r_size[22:0],
                               rd_sz - r_size[23:0] - 24'(HEADER_BYTES), 1'b1};
                    r_k <= r_cnt;
                    r_tgt <= r_i + CW'(1);
                    r_state <= (r_cnt > r_i + CW'(1)) ? S_SHR_RD : S_INS;
                    r_stop <= '0;
                    r_cnt <= r_cnt + CW'(1);
                end
                S_SHR_RD: r_state <= S_SHR_WR;
                S_SHR_WR: begin
                    r_k <= r_k - CW'(1);
                    r_state <= (r_k - CW'(1) > r_tgt) ? S_SHR_RD : S_INS;
                end
                S_INS: begin
                    if (r_stop == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= r_hold;
                        r_state <= S_MRG_RD;
                    end
                end
                S_MRG_RD: begin
                    r_tgt <= r_i;
                    r_state <= (r_i + CW'(1) < r_cnt) ? S_MRG_CHK : S_PRV_RD;
                    r_hit <= 1'b0;
                end
                S_MRG_CHK: begin
                    if (rd_fr) begin
                        r_cur <= {r_cur[EW-1 -: 23], r_cur[24:1] + rd_sz
                                  + 24'(HEADER_BYTES), 1'b1};
                        r_free <= r_free + 24'(HEADER_BYTES);
                        r_hit <= 1'b1;
                    end
                    r_state <= S_PRV_RD;
                end
                S_PRV_RD: begin
                    if (r_hit) begin
                        r_hit <= 1'b0;
                        r_hold <= r_cur;
                        r_k <= r_i + CW'(1);
                        r_cnt <= r_cnt - CW'(1);
                        r_tgt <= r_i;
                        r_stop <= CW'(2);
                        r_state <= S_INS_WR;
                    end else if (r_i != '0) begin
                        r_state <= S_PRV_CHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PRV_CHK: begin
                    if (rd_fr) begin
                        r_hold <= {rd_off, rd_sz + r_cur[24:1] + 24'(HEADER_BYTES), 1'b1};
                        r_free <= r_free + 24'(HEADER_BYTES);
                        r_tgt <= r_i - CW'(1);
                        r_k <= r_i;
                        r_cnt <= r_cnt - CW'(1);
                        r_stop <= CW'(3);
                        r_state <= S_INS_WR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INS_WR: begin
                    r_state <= (r_k < r_cnt) ? S_SHL_RD : S_SHL_END;
                end
                S_SHL_RD: r_state <= S_SHL_WR;
                S_SHL_WR: begin
                    r_k <= r_k + CW'(1);
                    r_state <= (r_k + CW'(1) < r_cnt) ? S_SHL_RD : S_SHL_END;
                end
                S_SHL_END: begin
                    if (r_stop == CW'(2) && r_i != '0) begin
                        r_stop <= CW'(3);
                        r_state <= S_PRV_CHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {6'd0, TOTAL, r_free, r_used, r_st, r_res};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 && r_cnt <= CW'(MAX_BLOCKS))
        else $error("block count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[25:24] != ffha_pkg::ST_OK |-> m_axis_tdata[23:0] == '0)
        else $error("failed result carries an address");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready)
        else $error("input taken while busy");
endmodule

>>> tb/tb_first_fit_heap_allocator_core.sv
// Testbench for the first-fit heap allocator: directed and random allocate/free traffic.
module tb_first_fit_heap_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAP   = ffha_pkg::HEAP_BYTES_DEF;
    localparam int unsigned NBLK   = ffha_pkg::MAX_BLOCKS_DEF;
    localparam int unsigned HDR    = ffha_pkg::HEADER_BYTES_DEF;
    localparam int unsigned ALN    = ffha_pkg::ALIGN_BYTES_DEF;
    localparam int unsigned SETTLE = 4 * NBLK + 40;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [23:0]       total;
        logic [23:0]       free;
        logic [23:0]       used;
        ffha_pkg::t_status status;
        logic [23:0]       addr;
    } t_heap_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [23:0]  i_cfg_wdata = '0;

    first_fit_heap_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the heap table
    logic        heap_on;
    logic [23:0] heap_base;
    logic [22:0] blk_off  [NBLK];
    logic [23:0] blk_size [NBLK];
    logic        blk_free [NBLK];
    int unsigned blk_cnt;
    logic [23:0] used_sum, free_sum;

    t_heap_result pending_results[$];
    logic [23:0]  live_addrs[$];
    int unsigned  errors = 0, n_sent = 0, n_checked = 0, n_split = 0, n_merge = 0;
    int unsigned  n_oom = 0, n_unknown = 0, idle_cycles = 0, out_hold = 0;
    bit           allow_gaps = 1'b1;

    function automatic logic [23:0] payload_of(int unsigned i);
        return heap_base + 24'(blk_off[i]) + 24'(HDR);
    endfunction

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
            blk_off[k] = blk_off[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic t_heap_result predict_heap(logic op, logic [23:0] req, logic [23:0] a);
        t_heap_result r;
        logic [24:0]  sz;
        int unsigned  i;
        r = '{total: 24'(HEAP), free: '0, used: '0, status: ffha_pkg::ST_OK, addr: '0};
        if (!heap_on || (op == ffha_pkg::OP_ALLOC && req == '0)
                || (op == ffha_pkg::OP_FREE && a == '0)) begin
            r.status = ffha_pkg::ST_INVALID;
        end else if (op == ffha_pkg::OP_ALLOC) begin
            sz = 25'(((25'(req) + 25'(ALN - 1)) / ALN) * ALN);
            r.status = ffha_pkg::ST_OOM;
            for (i = 0; i < blk_cnt; i++) begin
                if (blk_free[i] && 25'(blk_size[i]) >= sz) begin
                    if (26'(blk_size[i]) > 26'(sz) + 26'(HDR) + 26'(ALN) && blk_cnt < NBLK) begin
                        for (int unsigned k = blk_cnt; k > i + 1; k--) begin
                            blk_off[k] = blk_off[k-1];
                            blk_size[k] = blk_size[k-1];
                            blk_free[k] = blk_free[k-1];
                        end
                        blk_off[i+1] = blk_off[i] + 23'(HDR) + 23'(sz);
                        blk_size[i+1] = blk_size[i] - 24'(sz) - 24'(HDR);
                        blk_free[i+1] = 1'b1;
                        blk_cnt++;
                        blk_size[i] = 24'(sz);
                        free_sum -= 24'(sz) + 24'(HDR);
                        used_sum += 24'(sz);
                        n_split++;
                    end else begin
                        free_sum -= blk_size[i];
                        used_sum += blk_size[i];
                    end
                    blk_free[i] = 1'b0;
                    r.status = ffha_pkg::ST_OK;
                    r.addr = payload_of(i);
                    break;
                end
            end
        end else begin
            for (i = 0; i < blk_cnt; i++)
                if (payload_of(i) == a) break;
            if (i >= blk_cnt || blk_free[i]) begin
                r.status = ffha_pkg::ST_UNKNOWN;
            end else begin
                blk_free[i] = 1'b1;
                used_sum -= blk_size[i];
                free_sum += blk_size[i];
                if (i + 1 < blk_cnt && blk_free[i+1]) begin
                    blk_size[i] += blk_size[i+1] + 24'(HDR);
                    free_sum += 24'(HDR);
                    drop_entry(i + 1);
                    n_merge++;
                end
                if (i > 0 && blk_free[i-1]) begin
                    blk_size[i-1] += blk_size[i] + 24'(HDR);
                    free_sum += 24'(HDR);
                    drop_entry(i);
                    n_merge++;
                end
            end
        end
        if (r.status == ffha_pkg::ST_OOM) n_oom++;
        if (r.status == ffha_pkg::ST_UNKNOWN) n_unknown++;
        r.used = used_sum;
        r.free = free_sum;
        return r;
    endfunction

    task automatic tick();
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        tick();
        i_cfg_we <= 1'b0;
        if (idx == ffha_pkg::REG_ENABLE) heap_on = val[0];
        else heap_base = val;
        tick();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) tick();
        repeat (SETTLE) tick();
    endtask

    task automatic send_request(logic op, logic [23:0] req, logic [23:0] a);
        t_heap_result exp;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) tick();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {a, req};
        do tick(); while (!s_axis_tready);
        exp = predict_heap(op, req, a);
        pending_results.push_back(exp);
        if (op == ffha_pkg::OP_ALLOC && exp.status == ffha_pkg::ST_OK)
            live_addrs.push_back(exp.addr);
        n_sent++;
    endtask

    task automatic free_live(int unsigned pick);
        logic [23:0] a;
        a = live_addrs[pick];
        live_addrs.delete(pick);
        send_request(ffha_pkg::OP_FREE, 24'($urandom()), a);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_hold != 0) begin
                out_hold <= out_hold - 1;
                m_axis_tready <= (out_hold == 1);
            end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
                out_hold <= $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_heap_result got, exp;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_heap_result'(m_axis_tdata[97:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                n_checked++;
                if (got.addr !== exp.addr) begin
                    $error("result_address exp %h got %h", exp.addr, got.addr); errors++;
                end
                if (got.status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status); errors++;
                end
                if (got.used !== exp.used) begin
                    $error("used_bytes exp %h got %h", exp.used, got.used); errors++;
                end
                if (got.free !== exp.free) begin
                    $error("free_bytes exp %h got %h", exp.free, got.free); errors++;
                end
                if (got.total !== exp.total) begin
                    $error("total_bytes exp %h got %h", exp.total, got.total); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_disabled();
        send_request(ffha_pkg::OP_ALLOC, 24'd100, 24'd0);
        send_request(ffha_pkg::OP_FREE, 24'd0, 24'h200020);
        drain();
        write_reg(ffha_pkg::REG_ENABLE, 24'd1);
    endtask

    task automatic test_directed();
        send_request(ffha_pkg::OP_ALLOC, 24'd0, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'(HEAP - HDR + 1), 24'd0);
        send_request(ffha_pkg::OP_FREE, 24'd0, 24'd0);
        send_request(ffha_pkg::OP_FREE, 24'd0, 24'hFFFFFF);
        send_request(ffha_pkg::OP_ALLOC, 24'd1, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'd16, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'd17, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'd64, 24'd0);
        free_live(1);
        free_live(1);
        send_request(ffha_pkg::OP_FREE, 24'd0, 24'h200040);
        free_live(0);
        send_request(ffha_pkg::OP_ALLOC, 24'd48, 24'd0);
        send_request(ffha_pkg::OP_ALLOC, 24'd32, 24'd0);
        while (live_addrs.size() != 0) free_live(0);
        send_request(ffha_pkg::OP_ALLOC, 24'(HEAP - HDR), 24'd0);
        free_live(0);
        drain();
    endtask

    task automatic test_full_table();
        for (int k = 0; k < NBLK + 4; k++)
            send_request(ffha_pkg::OP_ALLOC, 24'($urandom_range(1, 200)), 24'd0);
        while (live_addrs.size() != 0) free_live($urandom_range(0, live_addrs.size() - 1));
        drain();
    endtask

    task automatic test_random(int unsigned count);
        logic [23:0] req;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: send_request(ffha_pkg::OP_ALLOC, 24'($urandom()), 24'($urandom()));
                1: send_request(ffha_pkg::OP_FREE, 24'($urandom()), 24'($urandom()));
                2, 3, 4: begin
                    req = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 1 << 21))
                                                      : 24'($urandom_range(1, 600));
                    send_request(ffha_pkg::OP_ALLOC, req, 24'($urandom()));
                end
                default: begin
                    if (live_addrs.size() != 0)
                        free_live($urandom_range(0, live_addrs.size() - 1));
                    else
                        send_request(ffha_pkg::OP_ALLOC, 24'($urandom_range(1, 4096)),
                                     24'($urandom()));
                end
            endcase
        end
    endtask

    task automatic test_base_moves();
        write_reg(ffha_pkg::REG_BASE, 24'h000000);
        test_random(150);
        drain();
        write_reg(ffha_pkg::REG_BASE, 24'hFFFFF0);
        live_addrs.delete();
        test_random(150);
        drain();
        write_reg(ffha_pkg::REG_ENABLE, 24'd0);
        test_random(30);
        drain();
        write_reg(ffha_pkg::REG_BASE, 24'h7FFFF0);
        write_reg(ffha_pkg::REG_ENABLE, 24'd1);
        live_addrs.delete();
        test_random(400);
        drain();
    endtask

    initial begin
        heap_on = 1'b0;
        heap_base = ffha_pkg::BASE_RESET;
        for (int k = 0; k < NBLK; k++) begin
            blk_off[k] = '0; blk_size[k] = '0; blk_free[k] = 1'b0;
        end
        blk_size[0] = 24'(HEAP - HDR);
        blk_free[0] = 1'b1;
        blk_cnt = 1;
        used_sum = '0;
        free_sum = 24'(HEAP - HDR);
        repeat (7) tick();
        i_rst_n <= 1'b1;
        tick();
        test_disabled();
        test_directed();
        test_full_table();
        test_random(600);
        drain();
        test_base_moves();
        allow_gaps = 1'b0;
        test_random(300);
        drain();
        $display("covered %0d requests, %0d results checked", n_sent, n_checked);
        $display("splits %0d, merges %0d, out of memory %0d, unknown %0d",
                 n_split, n_merge, n_oom, n_unknown);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
